// File: rtl/core/swerve_joystick_mixer_unit_macros.svh
// ----------------------------------------------------------------------------
// Swerve joystick mixer assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SWERVE_JOYSTICK_MIXER_UNIT_MACROS_SVH
`define SWERVE_JOYSTICK_MIXER_UNIT_MACROS_SVH

// same-cycle implication
`define SJM_ASSERT_IMP(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication
`define SJM_ASSERT_NXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: rtl/core/swjm_pkg.sv
// ----------------------------------------------------------------------------
// swjm_pkg
// Shared widths, constants and types of the swerve joystick mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swjm_pkg;

	localparam int CHAN_W   = 11;
	localparam int DZ_W     = 9;
	localparam int SCALE_W  = 11;
	localparam int LIMIT_W  = 15;
	localparam int SPEED_W  = 14;
	localparam int TARGET_W = 16;
	localparam int ANGLE_W  = 8;
	localparam int HOLD_W   = 6;
	localparam int SPD_W    = 12;  // signed speed before wheel gain

	localparam logic [CHAN_W-1:0] CHAN_CENTER = 11'd1000;

	localparam logic signed [ANGLE_W-1:0] ANGLE_ZERO = 8'sd0;
	localparam logic signed [ANGLE_W-1:0] ANGLE_DIAG = 8'sd45;
	localparam logic signed [ANGLE_W-1:0] ANGLE_SIDE = 8'sd90;

	// hold-off loads
	localparam logic [HOLD_W-1:0] HOLD_ROTATE = 6'd25;
	localparam logic [HOLD_W-1:0] HOLD_LARGE  = 6'd32;
	localparam logic [HOLD_W-1:0] HOLD_MID    = 6'd20;

	// steering change thresholds, degrees
	localparam logic [7:0] THR_ROTATE = 8'd20;
	localparam logic [7:0] THR_LARGE  = 8'd60;
	localparam logic [7:0] THR_MID    = 8'd30;

	// floor(x/5) = (x * 52429) >> 18, exact for x below 2^17
	localparam logic [15:0] DIV5_RECIP = 16'd52429;
	localparam int          DIV5_SHIFT = 18;

	// register map, word index
	localparam logic [1:0] REG_DEADBAND    = 2'd0;
	localparam logic [1:0] REG_ANGLE_SCALE = 2'd1;
	localparam logic [1:0] REG_ANGLE_LIMIT = 2'd2;

	localparam logic [DZ_W-1:0]    DEADBAND_RST    = 9'd50;
	localparam logic [SCALE_W-1:0] ANGLE_SCALE_RST = 11'd100;
	localparam logic [LIMIT_W-1:0] ANGLE_LIMIT_RST = 15'd9000;

	// stick decode result
	typedef struct packed {
		logic                            trans;     // a translation case matched
		logic                            rot;       // rotate channel deflected
		logic                            centered;  // both stick axes inside dead zone
		logic signed [ANGLE_W-1:0]       angle;     // translation angle
		logic signed [SPD_W-1:0]         speed;     // signed speed, rotate wins
	} mix_sel_t;

	typedef enum logic [1:0] {
		TGT_ZERO,
		TGT_ALIGN,
		TGT_CRAB
	} tgt_mode_t;

endpackage

`default_nettype wire

// File: rtl/core/swjm_translate.sv
// ----------------------------------------------------------------------------
// swjm_translate
// Channel centering, dead-zone classification and speed/angle selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swjm_translate (
	input  wire logic [swjm_pkg::CHAN_W-1:0] chan_lateral,
	input  wire logic [swjm_pkg::CHAN_W-1:0] chan_forward,
	input  wire logic [swjm_pkg::CHAN_W-1:0] chan_rotate,
	input  wire logic [swjm_pkg::DZ_W-1:0]   deadband,
	output swjm_pkg::mix_sel_t               sel
);

	logic signed [11:0] lat, fwd, rot;
	logic [10:0] lat_mag, fwd_mag, rot_mag, dz_x;
	logic        lat_gt, lat_lt, fwd_gt, fwd_lt, rot_gt;
	logic [11:0] mag_sum;
	logic [13:0] sum_x3;
	logic [29:0] div_prod;
	logic [10:0] diag_spd, side_spd, fwd_spd, rot_spd;

	assign lat = $signed({1'b0, chan_lateral} - {1'b0, swjm_pkg::CHAN_CENTER});
	assign fwd = $signed({1'b0, chan_forward} - {1'b0, swjm_pkg::CHAN_CENTER});
	assign rot = $signed({1'b0, chan_rotate}  - {1'b0, swjm_pkg::CHAN_CENTER});

	assign lat_mag = lat[11] ? 11'(-lat) : lat[10:0];
	assign fwd_mag = fwd[11] ? 11'(-fwd) : fwd[10:0];
	assign rot_mag = rot[11] ? 11'(-rot) : rot[10:0];
	assign dz_x    = {2'b00, deadband};

	assign lat_gt = lat_mag > dz_x;
	assign lat_lt = lat_mag < dz_x;
	assign fwd_gt = fwd_mag > dz_x;
	assign fwd_lt = fwd_mag < dz_x;
	assign rot_gt = rot_mag > dz_x;

	// diagonal: 3*(|L|+|F|)/5 by reciprocal
	assign mag_sum  = {1'b0, lat_mag} + {1'b0, fwd_mag};
	assign sum_x3   = {1'b0, mag_sum, 1'b0} + {2'b00, mag_sum};
	assign div_prod = {16'd0, sum_x3} * {14'd0, swjm_pkg::DIV5_RECIP};
	assign diag_spd = 11'(div_prod >> swjm_pkg::DIV5_SHIFT);

	// beyond-dead-zone magnitudes; only used where the compare holds
	assign side_spd = lat_mag - dz_x;
	assign fwd_spd  = fwd_mag - dz_x;
	assign rot_spd  = rot_mag - dz_x;

	always_comb begin
		sel          = '0;
		sel.angle    = swjm_pkg::ANGLE_ZERO;
		sel.centered = lat_lt && fwd_lt;
		if (lat_gt && fwd_gt) begin
			sel.trans = 1'b1;
			sel.angle = (lat[11] == fwd[11]) ? swjm_pkg::ANGLE_DIAG : -swjm_pkg::ANGLE_DIAG;
			sel.speed = fwd[11] ? -$signed({1'b0, diag_spd}) : $signed({1'b0, diag_spd});
		end else if (lat_gt && fwd_lt) begin
			// leftward stick still gives a positive speed
			sel.trans = 1'b1;
			sel.angle = lat[11] ? -swjm_pkg::ANGLE_SIDE : swjm_pkg::ANGLE_SIDE;
			sel.speed = $signed({1'b0, side_spd});
		end else if (lat_lt && fwd_gt) begin
			sel.trans = 1'b1;
			sel.angle = swjm_pkg::ANGLE_ZERO;
			sel.speed = fwd[11] ? -$signed({1'b0, fwd_spd}) : $signed({1'b0, fwd_spd});
		end
		if (rot_gt) begin
			sel.rot   = 1'b1;
			sel.speed = rot[11] ? -$signed({1'b0, rot_spd}) : $signed({1'b0, rot_spd});
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/swjm_target.sv
// ----------------------------------------------------------------------------
// swjm_target
// Steering count targets: angle times scale, clamped to +-limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swjm_target (
	input  wire swjm_pkg::tgt_mode_t                      mode,
	input  wire logic signed [swjm_pkg::ANGLE_W-1:0]      angle,
	input  wire logic [swjm_pkg::SCALE_W-1:0]             angle_scale,
	input  wire logic [swjm_pkg::LIMIT_W-1:0]             angle_limit,
	output logic signed [swjm_pkg::TARGET_W-1:0]          target_a,
	output logic signed [swjm_pkg::TARGET_W-1:0]          target_b,
	output logic signed [swjm_pkg::TARGET_W-1:0]          target_c,
	output logic signed [swjm_pkg::TARGET_W-1:0]          target_d
);

	logic signed [19:0] ang_x, scale_x, lim_x, prod;
	logic signed [19:0] clamped;
	logic signed [swjm_pkg::TARGET_W-1:0] pos, neg;

	assign ang_x   = {{12{angle[7]}}, angle};
	assign scale_x = {9'd0, angle_scale};
	assign lim_x   = {5'd0, angle_limit};
	assign prod    = ang_x * scale_x;

	always_comb begin
		if (prod > lim_x) begin
			clamped = lim_x;
		end else if (prod < -lim_x) begin
			clamped = -lim_x;
		end else begin
			clamped = prod;
		end
	end

	assign pos = clamped[swjm_pkg::TARGET_W-1:0];
	assign neg = -pos;

	always_comb begin
		case (mode)
			swjm_pkg::TGT_ALIGN: begin
				target_a = pos;
				target_b = pos;
				target_c = pos;
				target_d = pos;
			end
			swjm_pkg::TGT_CRAB: begin
				target_a = neg;
				target_b = pos;
				target_c = neg;
				target_d = pos;
			end
			default: begin
				target_a = '0;
				target_b = '0;
				target_c = '0;
				target_d = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/swerve_joystick_mixer_unit.sv
// ----------------------------------------------------------------------------
// swerve_joystick_mixer_unit
// Remote-control channels to four-wheel swerve drive speeds and steering targets.
// ----------------------------------------------------------------------------
// Takes one transfer of three RC channels (1000 = center) per clock and returns
// one result transfer per input: four drive speeds and four clamped steering
// count targets. Throughput is one item per cycle while out_stall is low; each
// item passes the input register, then the result register, with the whole mix
// (dead zone, divide-by-five reciprocal, hold-off update, 8x11 angle multiply
// and clamp) done in a single combinational pass between them. Steering state
// and the hold-off counter update in the same pass, so consecutive items chain
// without bubbles. out_stall backs up to in_stall in the same cycle once both
// registers are full. Wheel speeds freeze while the hold-off counter runs
// after a large steering change. Registers (APB, byte addresses 0x0, 0x4, 0x8):
// deadband, angle_scale, angle_limit; write them only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "swerve_joystick_mixer_unit_macros.svh"

module swerve_joystick_mixer_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// APB configuration
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [3:0]                             paddr,
	input  wire logic [31:0]                            pwdata,
	output logic [31:0]                                 prdata,
	output logic                                        pready,
	// input channel
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [swjm_pkg::CHAN_W-1:0]            chan_lateral,
	input  wire logic [swjm_pkg::CHAN_W-1:0]            chan_forward,
	input  wire logic [swjm_pkg::CHAN_W-1:0]            chan_rotate,
	// result channel
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [swjm_pkg::SPEED_W-1:0]         wheel_speed_a,
	output logic signed [swjm_pkg::SPEED_W-1:0]         wheel_speed_b,
	output logic signed [swjm_pkg::SPEED_W-1:0]         wheel_speed_c,
	output logic signed [swjm_pkg::SPEED_W-1:0]         wheel_speed_d,
	output logic signed [swjm_pkg::TARGET_W-1:0]        steer_target_a,
	output logic signed [swjm_pkg::TARGET_W-1:0]        steer_target_b,
	output logic signed [swjm_pkg::TARGET_W-1:0]        steer_target_c,
	output logic signed [swjm_pkg::TARGET_W-1:0]        steer_target_d
);

	// ---------------- configuration registers ----------------
	logic [swjm_pkg::DZ_W-1:0]    deadband_q;
	logic [swjm_pkg::SCALE_W-1:0] angle_scale_q;
	logic [swjm_pkg::LIMIT_W-1:0] angle_limit_q;
	logic                         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q    <= swjm_pkg::DEADBAND_RST;
			angle_scale_q <= swjm_pkg::ANGLE_SCALE_RST;
			angle_limit_q <= swjm_pkg::ANGLE_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				swjm_pkg::REG_DEADBAND:    deadband_q    <= pwdata[swjm_pkg::DZ_W-1:0];
				swjm_pkg::REG_ANGLE_SCALE: angle_scale_q <= pwdata[swjm_pkg::SCALE_W-1:0];
				swjm_pkg::REG_ANGLE_LIMIT: angle_limit_q <= pwdata[swjm_pkg::LIMIT_W-1:0];
				default: ;  // unmapped word: write ignored
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			swjm_pkg::REG_DEADBAND:    prdata = {23'd0, deadband_q};
			swjm_pkg::REG_ANGLE_SCALE: prdata = {21'd0, angle_scale_q};
			swjm_pkg::REG_ANGLE_LIMIT: prdata = {17'd0, angle_limit_q};
			default:                   prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	// s1: input register. s2: result register. adv moves s1 into s2 and
	// commits the steering state in the same edge.
	logic                          valid_s1, valid_s2;
	logic [swjm_pkg::CHAN_W-1:0]   lat_s1, fwd_s1, rot_s1;
	logic                          adv, in_xfer;

	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			lat_s1 <= chan_lateral;
			fwd_s1 <= chan_forward;
			rot_s1 <= chan_rotate;
		end
	end

	// ---------------- stick decode ----------------
	swjm_pkg::mix_sel_t sel;

	swjm_translate u_translate (
		.chan_lateral (lat_s1),
		.chan_forward (fwd_s1),
		.chan_rotate  (rot_s1),
		.deadband     (deadband_q),
		.sel          (sel)
	);

	// ---------------- steering state and hold-off ----------------
	logic signed [swjm_pkg::ANGLE_W-1:0] cur_angle_q, prev_angle_q;
	logic [swjm_pkg::HOLD_W-1:0]         holdoff_q;
	logic signed [swjm_pkg::SPEED_W-1:0] held_q [4];

	logic signed [swjm_pkg::ANGLE_W-1:0] cur_t, prev_t, cur_n, prev_n, tgt_angle;
	logic [swjm_pkg::HOLD_W-1:0]         hold_load, hold_n;
	logic                                hold_end;
	logic signed [swjm_pkg::SPEED_W-1:0] held_n [4];
	logic signed [swjm_pkg::SPEED_W-1:0] spd_x, spd_x3, spd_x6;
	logic [7:0]                          rot_dist, turn_dist;
	swjm_pkg::tgt_mode_t                 tgt_mode;

	function automatic logic [7:0] angle_dist(
		input logic signed [swjm_pkg::ANGLE_W-1:0] a,
		input logic signed [swjm_pkg::ANGLE_W-1:0] b
	);
		logic signed [8:0] d;
		d = {a[7], a} - {b[7], b};
		return d[8] ? 8'(-d) : d[7:0];
	endfunction

	// a translation case first moves the stored angle into previous
	assign cur_t  = sel.trans ? sel.angle : cur_angle_q;
	assign prev_t = sel.trans ? cur_angle_q : prev_angle_q;

	assign rot_dist  = angle_dist(cur_t, swjm_pkg::ANGLE_DIAG);
	assign turn_dist = angle_dist(prev_t, cur_t);

	// wheel gains wrap to the field width
	assign spd_x  = {{(swjm_pkg::SPEED_W - swjm_pkg::SPD_W){sel.speed[swjm_pkg::SPD_W-1]}},
	                 sel.speed};
	assign spd_x3 = (spd_x <<< 1) + spd_x;
	assign spd_x6 = spd_x3 <<< 1;

	always_comb begin
		cur_n     = cur_t;
		prev_n    = prev_t;
		hold_load = holdoff_q;
		tgt_angle = cur_t;
		tgt_mode  = swjm_pkg::TGT_ZERO;
		for (int i = 0; i < 4; i++) begin
			held_n[i] = held_q[i];
		end

		if (sel.rot) begin
			prev_n = cur_t;
			cur_n  = swjm_pkg::ANGLE_DIAG;
			if (rot_dist > swjm_pkg::THR_ROTATE) begin
				hold_load = swjm_pkg::HOLD_ROTATE;
			end
		end else if (!sel.centered) begin
			if (turn_dist > swjm_pkg::THR_LARGE) begin
				hold_load = swjm_pkg::HOLD_LARGE;
			end else if (turn_dist > swjm_pkg::THR_MID) begin
				hold_load = swjm_pkg::HOLD_MID;
			end
		end

		hold_end = hold_load <= 6'd1;

		if (sel.rot) begin
			hold_n = hold_end ? '0 : hold_load - 6'd1;
			if (hold_end) begin
				for (int i = 0; i < 4; i++) begin
					held_n[i] = spd_x3;
				end
				tgt_mode  = swjm_pkg::TGT_CRAB;
				tgt_angle = swjm_pkg::ANGLE_DIAG;
			end
		end else if (sel.centered) begin
			// centered stick: counter untouched, wheels stop
			hold_n = holdoff_q;
			cur_n  = swjm_pkg::ANGLE_ZERO;
			for (int i = 0; i < 4; i++) begin
				held_n[i] = '0;
			end
		end else begin
			hold_n   = hold_end ? '0 : hold_load - 6'd1;
			tgt_mode = swjm_pkg::TGT_ALIGN;
			if (hold_end) begin
				held_n[0] = -spd_x6;
				held_n[1] = -spd_x6;
				held_n[2] = spd_x6;
				held_n[3] = spd_x6;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_angle_q  <= swjm_pkg::ANGLE_ZERO;
			prev_angle_q <= swjm_pkg::ANGLE_ZERO;
			holdoff_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				held_q[i] <= '0;
			end
		end else if (adv) begin
			cur_angle_q  <= cur_n;
			prev_angle_q <= prev_n;
			holdoff_q    <= hold_n;
			for (int i = 0; i < 4; i++) begin
				held_q[i] <= held_n[i];
			end
		end
	end

	// ---------------- steering targets ----------------
	logic signed [swjm_pkg::TARGET_W-1:0] tgt_a, tgt_b, tgt_c, tgt_d;
	logic signed [swjm_pkg::TARGET_W-1:0] tgt_a_s2, tgt_b_s2, tgt_c_s2, tgt_d_s2;

	swjm_target u_target (
		.mode        (tgt_mode),
		.angle       (tgt_angle),
		.angle_scale (angle_scale_q),
		.angle_limit (angle_limit_q),
		.target_a    (tgt_a),
		.target_b    (tgt_b),
		.target_c    (tgt_c),
		.target_d    (tgt_d)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			tgt_a_s2 <= tgt_a;
			tgt_b_s2 <= tgt_b;
			tgt_c_s2 <= tgt_c;
			tgt_d_s2 <= tgt_d;
		end
	end

	// ---------------- result ports ----------------
	// held speeds change only on adv, so they double as the result register
	assign out_valid      = valid_s2;
	assign wheel_speed_a  = held_q[0];
	assign wheel_speed_b  = held_q[1];
	assign wheel_speed_c  = held_q[2];
	assign wheel_speed_d  = held_q[3];
	assign steer_target_a = tgt_a_s2;
	assign steer_target_b = tgt_b_s2;
	assign steer_target_c = tgt_c_s2;
	assign steer_target_d = tgt_d_s2;

	// ---------------- assertions ----------------
	`SJM_ASSERT_NXT(a_rot_sets_diag, adv && sel.rot, cur_angle_q == swjm_pkg::ANGLE_DIAG, "rotate item did not leave 45 degrees")
	`SJM_ASSERT_NXT(a_center_stops, adv && sel.centered && !sel.rot, wheel_speed_a == '0 && wheel_speed_d == '0 && steer_target_a == '0 && steer_target_d == '0, "centered item gave nonzero outputs")
	`SJM_ASSERT_IMP(a_wheel_pairs, out_valid, wheel_speed_a == wheel_speed_b && wheel_speed_c == wheel_speed_d, "wheel speed pairs differ")

endmodule

`default_nettype wire
